// ----- rtl/frame_ring_sequence_buffer_assert.svh -----
// Assertion macros shared by the frame ring sequence buffer RTL.
// Depends on signals named clock and reset in the including module.
`ifndef FRAME_RING_SEQUENCE_BUFFER_ASSERT_SVH
`define FRAME_RING_SEQUENCE_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define FRSB_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FRSB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/frsb_pkg.sv -----
// Package for the frame ring sequence buffer: transaction payload types,
// action codes and configuration register indexes. No dependencies.
`default_nettype none

package frsb_pkg;

   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM    = 2'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] push_word;
      logic [5:0]  frame_offset;
      logic [5:0]  column;
   } req_type;

   typedef struct packed {
      logic [31:0] read_word;
      logic [6:0]  frames_held;
      logic        ring_full;
      logic        is_padding;
      logic        out_of_range;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/frsb_ram.sv -----
// Simple dual-port word store with a registered read port.
// No dependencies; the depth and address width come from the parameters.
`default_nettype none

module frsb_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [31:0]   rd_data
);

   logic [31:0] store_mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/frame_ring_sequence_buffer.sv -----
// Frame ring sequence buffer: a ring of feature frames held in one word memory.
// A result passes through the pending stage and then the output register.
// Throughput: one transaction per cycle unless a stall or register write holds
// requests back; each push or read uses one port of the dual-port word store.
// Reset is synchronous and active high; it clears the ring pointers and the
// handshake state and restores each size register to its limit, capped at 64.
`default_nettype none

`include "frame_ring_sequence_buffer_assert.svh"

module frame_ring_sequence_buffer #(
   parameter int MAX_FRAMES = 64,
   parameter int MAX_DIM    = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire frsb_pkg::req_type                req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output frsb_pkg::rsp_type                     rsp_payload,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [frsb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [frsb_pkg::CFG_W-1:0]       csr_wdata
);

   import frsb_pkg::*;

   // Widths that follow from the ring size limits.
   localparam int DEPTH = MAX_FRAMES * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = $clog2(MAX_FRAMES + 1);
   localparam int DW    = $clog2(MAX_DIM + 1);

   localparam logic [FW-1:0] FRAMES_RST = FW'((MAX_FRAMES < 64) ? MAX_FRAMES : 64);
   localparam logic [DW-1:0] DIM_RST    = DW'((MAX_DIM < 64) ? MAX_DIM : 64);

   // A size of zero counts as one; a size above the limit counts as the limit.
   function automatic logic [FW-1:0] clamp_frames(logic [CFG_W-1:0] v);
      if (v == '0) return FW'(1);
      if (32'(v) > 32'(MAX_FRAMES)) return FW'(MAX_FRAMES);
      return FW'(v);
   endfunction

   function automatic logic [DW-1:0] clamp_dim(logic [CFG_W-1:0] v);
      if (v == '0) return DW'(1);
      if (32'(v) > 32'(MAX_DIM)) return DW'(MAX_DIM);
      return DW'(v);
   endfunction

   // Complete frames: once wrapped, a partly overwritten head frame is not counted.
   function automatic logic [FW-1:0] held_of(logic full, logic [DW-1:0] cc,
                                             logic [FW-1:0] head, logic [FW-1:0] fiu);
      if (full) return (cc != '0) ? fiu - FW'(1) : fiu;
      return head;
   endfunction

   // Configuration and ring pointers.
   logic [FW-1:0] fiu_ff, fiu_in;
   logic [DW-1:0] dim_ff, dim_in;
   logic [FW-1:0] head_ff, head_in;
   logic [DW-1:0] cc_ff, cc_in;
   logic          full_ff, full_in;

   // Pending stage: status is ready, the word arrives from the memory.
   logic          pend_ff, pend_in;
   logic          pend_use_mem_ff, pend_use_mem_in;
   rsp_type       pend_rsp_ff, pend_rsp_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_payload_ff, rsp_payload_in;

   // Handshake.
   logic          pend_move;
   logic          req_fire;
   logic          csr_fire;

   // Memory side.
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;

   // Read decode.
   logic [FW-1:0] held_now;
   logic [FW-1:0] oldest;
   logic [31:0]   frame_sum;
   logic [31:0]   frame_sel;
   logic          rd_oor;
   logic          rd_pad;
   logic [DW-1:0] cc_inc;
   logic [FW-1:0] head_inc;

   // The pending stage drains into the output register whenever that register
   // is empty or its transaction is being taken; a new request may enter the
   // pending stage in the same cycle. A request waits while a register write
   // is taken, so that it sees the restarted ring in the following cycle.
   assign pend_move = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (pend_ff && !pend_move) || csr_fire;
   assign req_fire  = req_valid && !req_stall;
   // Configuration is taken only while nothing is in flight.
   assign csr_ready = !pend_ff && !rsp_valid_ff;
   assign csr_fire  = csr_valid && csr_ready;

   // Read address: the oldest frame is frame zero until the ring wraps, then
   // the head frame, or the frame after it while the head frame is torn.
   always_comb begin
      held_now = held_of(full_ff, cc_ff, head_ff, fiu_ff);
      oldest   = '0;
      if (full_ff) begin
         if (cc_ff != '0) begin
            oldest = (32'(head_ff) + 32'd1 >= 32'(fiu_ff)) ? '0 : head_ff + FW'(1);
         end else begin
            oldest = head_ff;
         end
      end
      frame_sum = 32'(oldest) + 32'(req_payload.frame_offset);
      frame_sel = (frame_sum >= 32'(fiu_ff)) ? frame_sum - 32'(fiu_ff) : frame_sum;
      rd_oor    = (32'(req_payload.frame_offset) >= 32'(fiu_ff))
               || (32'(req_payload.column) >= 32'(dim_ff));
      rd_pad    = !rd_oor && (32'(req_payload.frame_offset) >= 32'(held_now));
   end

   assign mem_rd_en   = req_fire && (req_payload.action == ACT_READ) && !rd_oor && !rd_pad;
   assign mem_rd_addr = AW'(frame_sel * 32'(MAX_DIM) + 32'(req_payload.column));
   assign mem_wr_en   = req_fire && (req_payload.action == ACT_PUSH);
   assign mem_wr_addr = AW'(32'(head_ff) * 32'(MAX_DIM) + 32'(cc_ff));

   assign cc_inc   = cc_ff + DW'(1);
   assign head_inc = head_ff + FW'(1);

   // Pointer and size updates.
   always_comb begin
      fiu_in  = fiu_ff;
      dim_in  = dim_ff;
      head_in = head_ff;
      cc_in   = cc_ff;
      full_in = full_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_FRAMES: begin
               fiu_in  = clamp_frames(csr_wdata);
               head_in = '0;
               cc_in   = '0;
               full_in = 1'b0;
            end
            CSR_DIM: begin
               dim_in  = clamp_dim(csr_wdata);
               head_in = '0;
               cc_in   = '0;
               full_in = 1'b0;
            end
            default: begin
            end
         endcase
      end else if (req_fire) begin
         unique case (req_payload.action)
            ACT_PUSH: begin
               if (32'(cc_inc) >= 32'(dim_ff)) begin
                  cc_in = '0;
                  if (32'(head_inc) >= 32'(fiu_ff)) begin
                     head_in = '0;
                     full_in = 1'b1;
                  end else begin
                     head_in = head_inc;
                  end
               end else begin
                  cc_in = cc_inc;
               end
            end
            ACT_CLEAR: begin
               head_in = '0;
               cc_in   = '0;
               full_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Pending stage and output register. Status reflects the state after the
   // action; the word is zero for everything but an in-range, held read.
   always_comb begin
      pend_in         = pend_ff;
      pend_use_mem_in = pend_use_mem_ff;
      pend_rsp_in     = pend_rsp_ff;
      if (pend_move) begin
         pend_in = 1'b0;
      end
      if (req_fire) begin
         pend_in                  = 1'b1;
         pend_use_mem_in          = mem_rd_en;
         pend_rsp_in.read_word    = '0;
         pend_rsp_in.frames_held  = 7'(held_of(full_in, cc_in, head_in, fiu_in));
         pend_rsp_in.ring_full    = full_in;
         pend_rsp_in.is_padding   = (req_payload.action == ACT_READ) && rd_pad;
         pend_rsp_in.out_of_range = (req_payload.action == ACT_READ) && rd_oor;
      end

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (pend_move) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in           = pend_rsp_ff;
         rsp_payload_in.read_word = pend_use_mem_ff ? mem_rd_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff       <= FRAMES_RST;
         dim_ff       <= DIM_RST;
         head_ff      <= '0;
         cc_ff        <= '0;
         full_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fiu_ff       <= fiu_in;
         dim_ff       <= dim_in;
         head_ff      <= head_in;
         cc_ff        <= cc_in;
         full_ff      <= full_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_use_mem_ff <= pend_use_mem_in;
      pend_rsp_ff     <= pend_rsp_in;
      rsp_payload_ff  <= rsp_payload_in;
   end

   frsb_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_payload.push_word),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `FRSB_ASSERT_IMPL(a_head_range, 1'b1, head_ff < fiu_ff, "head frame beyond ring size")
   `FRSB_ASSERT_IMPL(a_col_range, 1'b1, cc_ff < dim_ff, "column count beyond frame size")
   `FRSB_ASSERT_IMPL(a_flags_excl, pend_ff, !(pend_rsp_ff.is_padding && pend_rsp_ff.out_of_range),
      "padding and out of range both set")
   `FRSB_ASSERT_NEXT(a_rd_pending, mem_rd_en, pend_ff && pend_use_mem_ff,
      "memory read issued without a pending transaction")

endmodule

`default_nettype wire
